>>> src/fdfr_pkg.sv
// types and constants shared by the force dead zone and rotation block
`timescale 1ns / 1ps
`default_nettype none
package fdfr_pkg;

	localparam int FORCE_W = 24;
	localparam int ROT_W   = 16;
	localparam int THR_W   = 23;
	localparam int OUT_W   = 26;
	localparam int PROD_W  = FORCE_W + ROT_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int FRAC_W  = 14;
	localparam int SHR_W   = SUM_W - FRAC_W;
	localparam int NUM_ROT = 9;
	localparam int IN_W    = 3 * FORCE_W + NUM_ROT * ROT_W;
	localparam int OUT_PAD_W = ((3 * OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd2;

	localparam logic [THR_W-1:0] LOWER_RST = 23'd768;
	localparam logic [THR_W-1:0] UPPER_RST = 23'd25600;

	localparam logic signed [SHR_W-1:0] OUT_MAX = 28'sd25165824;
	localparam logic signed [SHR_W-1:0] OUT_MIN = -28'sd25165824;

	typedef logic signed [FORCE_W-1:0] force_t;
	typedef logic signed [ROT_W-1:0]   rot_t;
	typedef logic signed [OUT_W-1:0]   out_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef rot_t [NUM_ROT-1:0]        rot_mat_t;

	typedef struct packed {
		logic [THR_W-1:0] lower;
		logic [THR_W-1:0] upper;
	} thr_t;

endpackage
`default_nettype wire

>>> src/force_deadband_frame_rotation.sv
// top level: force dead zone, axis remap and frame rotation stream block
//
// input words arrive on s_tvalid/s_tready/s_tdata: force x, y, z (24 bits each)
// then the nine Q1.14 rotation entries, row-major, 16 bits each
// result words leave on m_tvalid/m_tready/m_tdata: base frame force x, y, z,
// 26 bits each, zero padded to 80 bits
// thresholds and enable are written on cfg_wr_en/cfg_index/cfg_wdata
// a word taken from s_tdata passes the input, dead zone, multiplier and
// output registers in that order before its result is on m_tdata
// one word per cycle while m_tready is high, set by a four-register pipeline:
// input register, dead zone register, multiplier register, output register
// each stage takes new data when it is empty or the next stage moves on,
// so a stalled receiver only backs up the pipeline once every stage is full
// with enable at 0 the output register keeps its last value for each word
// reset clears all valid flags, the held result to zero and loads the
// threshold reset values; enable resets to 0
`timescale 1ns / 1ps
`default_nettype none
module force_deadband_frame_rotation (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// force_x, force_y, force_z, rot_00 .. rot_22
	input  wire  [fdfr_pkg::IN_W-1:0]         s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// base_force_x, base_force_y, base_force_z, zero padding
	output logic [fdfr_pkg::OUT_PAD_W-1:0]    m_tdata,
	input  wire                               cfg_wr_en,
	input  wire  [fdfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [fdfr_pkg::THR_W-1:0]        cfg_wdata
);
	import fdfr_pkg::*;

	thr_t     thr_q;
	logic     enable_q;

	logic     v_s1, v_s2, v_s3;
	logic     rdy2, rdy3, out_rdy;

	force_t   fx_s1, fy_s1, fz_s1;
	rot_mat_t rot_s1, rot_s2;
	force_t   dx, dy, dz;
	force_t   p0_s2, p1_s2, p2_s2;
	out_t     row0, row1, row2;
	out_t     res_q [3];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.lower <= LOWER_RST;
			thr_q.upper <= UPPER_RST;
			enable_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LOWER:  thr_q.lower <= cfg_wdata;
				REG_UPPER:  thr_q.upper <= cfg_wdata;
				REG_ENABLE: enable_q    <= cfg_wdata[0];
				default:    ;
			endcase
		end
	end

	assign out_rdy  = !m_tvalid || m_tready;
	assign rdy3     = !v_s3 || out_rdy;
	assign rdy2     = !v_s2 || rdy3;
	assign s_tready = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
			if (out_rdy)  m_tvalid <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			fx_s1  <= s_tdata[FORCE_W-1:0];
			fy_s1  <= s_tdata[2*FORCE_W-1:FORCE_W];
			fz_s1  <= s_tdata[3*FORCE_W-1:2*FORCE_W];
			rot_s1 <= s_tdata[IN_W-1:3*FORCE_W];
		end
	end

	fdfr_deadzone u_dz_x (.din(fx_s1), .thr(thr_q), .dout(dx));
	fdfr_deadzone u_dz_y (.din(fy_s1), .thr(thr_q), .dout(dy));
	fdfr_deadzone u_dz_z (.din(fz_s1), .thr(thr_q), .dout(dz));

	// remapped axes (y, x, -z)
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			p0_s2  <= dy;
			p1_s2  <= dx;
			p2_s2  <= -dz;
			rot_s2 <= rot_s1;
		end
	end

	fdfr_rotate u_rot (
		.clk  (clk),
		.load (rdy3 && v_s2),
		.p0   (p0_s2),
		.p1   (p1_s2),
		.p2   (p2_s2),
		.rot  (rot_s2),
		.row0 (row0),
		.row1 (row1),
		.row2 (row2)
	);

	// output register doubles as the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
		end else if (out_rdy && v_s3 && enable_q) begin
			res_q[0] <= row0;
			res_q[1] <= row1;
			res_q[2] <= row2;
		end
	end

	assign m_tdata = {{(OUT_PAD_W - 3*OUT_W){1'b0}}, res_q[2], res_q[1], res_q[0]};

endmodule
`default_nettype wire

>>> src/fdfr_deadzone.sv
// dead zone with upper cutoff for one force axis
`timescale 1ns / 1ps
`default_nettype none
module fdfr_deadzone (
	input  fdfr_pkg::force_t din,
	input  fdfr_pkg::thr_t   thr,
	output fdfr_pkg::force_t dout
);
	import fdfr_pkg::*;

	logic [FORCE_W-1:0] mag;
	logic [FORCE_W-1:0] lower_x;
	logic [FORCE_W-1:0] upper_x;
	logic               pass;

	assign lower_x = {1'b0, thr.lower};
	assign upper_x = {1'b0, thr.upper};
	assign mag     = din[FORCE_W-1] ? (~din + 1'b1) : din;
	assign pass    = (mag >= lower_x) && (mag <= upper_x);

	always_comb begin
		if (!pass) begin
			dout = '0;
		end else if (din[FORCE_W-1]) begin
			dout = din + force_t'(lower_x);
		end else begin
			dout = din - force_t'(lower_x);
		end
	end

endmodule
`default_nettype wire

>>> src/fdfr_rotate.sv
// product registers and row sums with floor shift and saturation
`timescale 1ns / 1ps
`default_nettype none
module fdfr_rotate (
	input  wire                 clk,
	input  wire                 load,
	input  fdfr_pkg::force_t    p0,
	input  fdfr_pkg::force_t    p1,
	input  fdfr_pkg::force_t    p2,
	input  fdfr_pkg::rot_mat_t  rot,
	output fdfr_pkg::out_t      row0,
	output fdfr_pkg::out_t      row1,
	output fdfr_pkg::out_t      row2
);
	import fdfr_pkg::*;

	prod_t prod_s3 [NUM_ROT];
	force_t pv [3];
	sum_t   sum   [3];
	logic signed [SHR_W-1:0] shr [3];
	out_t   res   [3];

	assign pv[0] = p0;
	assign pv[1] = p1;
	assign pv[2] = p2;

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_ROT; k++) begin
				prod_s3[k] <= $signed(rot[k]) * $signed(pv[k % 3]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = sum_t'(prod_s3[3*i]) + sum_t'(prod_s3[3*i+1])
				+ sum_t'(prod_s3[3*i+2]);
			shr[i] = sum[i][SUM_W-1:FRAC_W];
			if (shr[i] > OUT_MAX) begin
				res[i] = OUT_MAX[OUT_W-1:0];
			end else if (shr[i] < OUT_MIN) begin
				res[i] = OUT_MIN[OUT_W-1:0];
			end else begin
				res[i] = shr[i][OUT_W-1:0];
			end
		end
	end

	assign row0 = res[0];
	assign row1 = res[1];
	assign row2 = res[2];

endmodule
`default_nettype wire
